// ===== hdl/dps_pkg.sv =====
// Shared constants and types for the DFA pattern scanner.
`timescale 1ns / 1ps

package dps_pkg;

  localparam int NumDfaDefault    = 2;
  localparam int MaxStatesDefault = 1024;

  // Request kinds on the input channel.
  localparam logic [2:0] KIND_LOAD_NEXT = 3'd0;
  localparam logic [2:0] KIND_LOAD_MARK = 3'd1;
  localparam logic [2:0] KIND_LOAD_USED = 3'd2;
  localparam logic [2:0] KIND_BEGIN     = 3'd3;
  localparam logic [2:0] KIND_BYTE      = 3'd4;

  // Control for one access to the table memories.
  typedef struct packed {
    logic       tbl_we;
    logic       mark_we;
    logic       rd_en;
    logic [7:0] col;
    logic [9:0] next_state;
    logic       mark;
  } dps_mem_ctl_t;

endpackage

// ===== hdl/dps_tables.sv =====
// Transition table and match mark memories, one access per cycle, registered reads.
`timescale 1ns / 1ps

module dps_tables #(
  parameter int NUM_DFA    = dps_pkg::NumDfaDefault,
  parameter int MAX_STATES = dps_pkg::MaxStatesDefault,
  localparam int RowW      = $clog2(NUM_DFA * MAX_STATES)
) (
  input  logic                 clk_i,
  input  dps_pkg::dps_mem_ctl_t ctl_i,
  input  logic [RowW-1:0]      row_i,
  output logic [9:0]           next_state_o,
  output logic                 mark_o
);
  import dps_pkg::*;

  localparam int MarkDepth = NUM_DFA * MAX_STATES;
  localparam int TblDepth  = MarkDepth * 256;

  logic [9:0] tbl_mem  [TblDepth];
  logic       mark_mem [MarkDepth];
  logic [9:0] tbl_rd_q;
  logic       mark_rd_q;

  // Read data holds while no read is issued, so a stalled lookup keeps its result.
  always_ff @(posedge clk_i) begin
    if (ctl_i.tbl_we) begin
      tbl_mem[{row_i, ctl_i.col}] <= ctl_i.next_state;
    end
    if (ctl_i.rd_en) begin
      tbl_rd_q <= tbl_mem[{row_i, ctl_i.col}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mark_we) begin
      mark_mem[row_i] <= ctl_i.mark;
    end
    if (ctl_i.rd_en) begin
      mark_rd_q <= mark_mem[row_i];
    end
  end

  assign next_state_o = tbl_rd_q;
  assign mark_o       = mark_rd_q;

endmodule

// ===== hdl/dfa_pattern_scan_top.sv =====
// Top level of the DFA pattern scanner: request decode, scan state and result staging.
`timescale 1ns / 1ps

// Usage: every request on the input channel (valid/ready) is a table load, a used
// count load, a packet begin or a packet data byte, and each yields exactly one
// result on the output channel (valid/ready) in request order.
// Loads and begins must come before the bytes that depend on them, as any stream.
// The table and mark memories are read at the accepting edge, where the lookup
// stage registers the request, and the output register then captures the
// resolved result from the lookup stage. Throughput is one request per cycle while
// the output is not stalled, also for consecutive data bytes: the next-state read
// loop closes with the read data forwarded straight into the address of the next lookup.
// At reset the used counts are zero, the state and alert are zero and the scan is
// stopped; the memories are not cleared and must be loaded before use.
// When the receiver stalls, one result waits in the output register and a second
// in the lookup stage; input ready then drops until the output drains.

module dfa_pattern_scan_top #(
  parameter int NUM_DFA    = dps_pkg::NumDfaDefault,
  parameter int MAX_STATES = dps_pkg::MaxStatesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic        dfa_index_i,
  input  logic [9:0]  state_index_i,
  input  logic [7:0]  byte_value_i,
  input  logic [9:0]  next_state_i,
  input  logic        match_mark_i,
  input  logic [10:0] used_states_i,
  input  logic [9:0]  start_state_i,
  input  logic        start_alert_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  flow_state_o,
  output logic        alert_o,
  output logic        scan_stopped_o,
  output logic        packet_done_o
);
  import dps_pkg::*;

  localparam int RowW = $clog2(NUM_DFA * MAX_STATES);
  localparam int UcW  = $clog2(MAX_STATES + 1);

  // Committed scan state.
  logic [9:0]     state_q, state_d;
  logic           alert_q, alert_d;
  logic           stopped_q, stopped_d;
  logic           dfa_q, dfa_d;
  logic [UcW-1:0] used_q [NUM_DFA];
  logic [UcW-1:0] used_d [NUM_DFA];

  // Lookup stage.
  logic       s1_valid_q, s1_valid_d;
  logic       pend_q, pend_d;
  logic [9:0] pend_state_q, pend_state_d;
  logic       pend_last_q, pend_last_d;
  logic [9:0] s1_state_q, s1_state_d;
  logic       s1_alert_q, s1_alert_d;
  logic       s1_stop_q, s1_stop_d;
  logic       s1_done_q, s1_done_d;

  // Output register.
  logic       out_valid_q, out_valid_d;
  logic [9:0] out_state_q, out_state_d;
  logic       out_alert_q, out_alert_d;
  logic       out_stop_q, out_stop_d;
  logic       out_done_q, out_done_d;

  dps_mem_ctl_t    mem_ctl;
  logic [RowW-1:0] mem_row;
  logic [9:0]      tbl_rd;
  logic            mark_rd;

  logic           s1_move, accept;
  logic [9:0]     cur_state;
  logic           cur_alert, cur_stopped;
  logic [9:0]     s1_res_state;
  logic           s1_res_alert, s1_res_stop, s1_res_done;
  logic           dfa_ok, sidx_ok, lookup_ok, bad_start;
  logic [UcW-1:0] limit, used_sat;
  logic [RowW-1:0] wr_row, rd_row;

  dps_tables #(
    .NUM_DFA   (NUM_DFA),
    .MAX_STATES(MAX_STATES)
  ) u_tables (
    .clk_i       (clk_i),
    .ctl_i       (mem_ctl),
    .row_i       (mem_row),
    .next_state_o(tbl_rd),
    .mark_o      (mark_rd)
  );

  assign s1_move    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_move;
  assign accept     = in_valid_i && in_ready_o;

  // A pending byte lookup resolves here from the memory read data; this is the
  // scan state that the next request sees.
  assign cur_state   = pend_q ? (mark_rd ? pend_state_q : tbl_rd) : state_q;
  assign cur_alert   = pend_q ? (mark_rd | alert_q) : alert_q;
  assign cur_stopped = pend_q ? (mark_rd | pend_last_q) : stopped_q;

  assign s1_res_state = pend_q ? cur_state : s1_state_q;
  assign s1_res_alert = pend_q ? cur_alert : s1_alert_q;
  assign s1_res_stop  = pend_q ? mark_rd : s1_stop_q;
  assign s1_res_done  = pend_q ? (mark_rd | pend_last_q) : s1_done_q;

  assign dfa_ok    = 32'(dfa_index_i) < NUM_DFA;
  assign sidx_ok   = 32'(state_index_i) < MAX_STATES;
  assign lookup_ok = (32'(dfa_q) < NUM_DFA) && (32'(cur_state) < MAX_STATES);
  assign used_sat  = (32'(used_states_i) > MAX_STATES) ? UcW'(MAX_STATES) : UcW'(used_states_i);
  assign bad_start = 32'(start_state_i) >= 32'(limit);

  assign wr_row = dfa_index_i ? RowW'(MAX_STATES) + RowW'(state_index_i)
                              : RowW'(state_index_i);
  assign rd_row = dfa_q ? RowW'(MAX_STATES) + RowW'(cur_state) : RowW'(cur_state);

  always_comb begin
    limit = '0;
    for (int i = 0; i < NUM_DFA; i++) begin
      if (32'(dfa_index_i) == i) begin
        limit = used_q[i];
      end
    end
  end

  always_comb begin
    state_d      = cur_state;
    alert_d      = cur_alert;
    stopped_d    = cur_stopped;
    dfa_d        = dfa_q;
    used_d       = used_q;
    s1_valid_d   = s1_valid_q && !s1_move;
    pend_d       = pend_q && !s1_move;
    pend_state_d = pend_state_q;
    pend_last_d  = pend_last_q;
    s1_state_d   = s1_state_q;
    s1_alert_d   = s1_alert_q;
    s1_stop_d    = s1_stop_q;
    s1_done_d    = s1_done_q;

    mem_ctl            = '0;
    mem_ctl.col        = byte_value_i;
    mem_ctl.next_state = next_state_i;
    mem_ctl.mark       = match_mark_i;
    mem_row            = wr_row;

    if (accept) begin
      s1_valid_d = 1'b1;
      pend_d     = 1'b0;
      s1_state_d = cur_state;
      s1_alert_d = cur_alert;
      s1_stop_d  = cur_stopped;
      s1_done_d  = 1'b0;
      unique case (kind_i)
        KIND_LOAD_NEXT: begin
          mem_ctl.tbl_we = dfa_ok && sidx_ok;
        end
        KIND_LOAD_MARK: begin
          mem_ctl.mark_we = dfa_ok && sidx_ok;
        end
        KIND_LOAD_USED: begin
          for (int i = 0; i < NUM_DFA; i++) begin
            if (32'(dfa_index_i) == i) begin
              used_d[i] = used_sat;
            end
          end
        end
        KIND_BEGIN: begin
          dfa_d      = dfa_index_i;
          state_d    = start_state_i;
          alert_d    = bad_start ? 1'b0 : start_alert_i;
          stopped_d  = bad_start;
          s1_state_d = start_state_i;
          s1_alert_d = bad_start ? 1'b0 : start_alert_i;
          s1_stop_d  = bad_start;
          s1_done_d  = bad_start;
        end
        KIND_BYTE: begin
          if (cur_stopped) begin
            s1_stop_d = 1'b1;
            s1_done_d = 1'b1;
          end else if (!lookup_ok) begin
            alert_d    = 1'b0;
            stopped_d  = 1'b1;
            s1_alert_d = 1'b0;
            s1_stop_d  = 1'b1;
            s1_done_d  = 1'b1;
          end else begin
            mem_ctl.rd_en = 1'b1;
            mem_row       = rd_row;
            pend_d        = 1'b1;
            pend_state_d  = cur_state;
            pend_last_d   = last_byte_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_state_d = out_state_q;
    out_alert_d = out_alert_q;
    out_stop_d  = out_stop_q;
    out_done_d  = out_done_q;
    if (s1_valid_q && s1_move) begin
      out_valid_d = 1'b1;
      out_state_d = s1_res_state;
      out_alert_d = s1_res_alert;
      out_stop_d  = s1_res_stop;
      out_done_d  = s1_res_done;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      alert_q     <= 1'b0;
      stopped_q   <= 1'b1;
      dfa_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_DFA; i++) begin
        used_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      alert_q     <= alert_d;
      stopped_q   <= stopped_d;
      dfa_q       <= dfa_d;
      s1_valid_q  <= s1_valid_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      used_q      <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_state_q <= pend_state_d;
    pend_last_q  <= pend_last_d;
    s1_state_q   <= s1_state_d;
    s1_alert_q   <= s1_alert_d;
    s1_stop_q    <= s1_stop_d;
    s1_done_q    <= s1_done_d;
    out_state_q  <= out_state_d;
    out_alert_q  <= out_alert_d;
    out_stop_q   <= out_stop_d;
    out_done_q   <= out_done_d;
  end

  assign out_valid_o    = out_valid_q;
  assign flow_state_o   = out_state_q;
  assign alert_o        = out_alert_q;
  assign scan_stopped_o = out_stop_q;
  assign packet_done_o  = out_done_q;

endmodule
